FILE: sv/tie_pkg.sv
// ----------------------------------------------------------------------------
// tie_pkg
// Shared types and constants of the toy ISA execute unit: operation codes,
// the decoded instruction record and the execute result record.
// ----------------------------------------------------------------------------
package tie_pkg;

  localparam int DATA_W   = 32;
  localparam int PC_W     = 10;
  localparam int MODE_W   = 4;
  localparam int DEST_W   = 10;
  localparam int TARGET_W = 11;

  typedef enum logic [MODE_W-1:0] {
    OP_ADD   = 4'd0,
    OP_NEG   = 4'd1,
    OP_MUL   = 4'd2,
    OP_JMP   = 4'd3,
    OP_JMP0  = 4'd4,
    OP_ASS   = 4'd5,
    OP_LE    = 4'd6,
    OP_READ  = 4'd7,
    OP_WRITE = 4'd8,
    OP_HALT  = 4'd9
  } op_t;

  // decoded instruction as held between accept and execute
  typedef struct packed {
    logic [MODE_W-1:0]   mode;
    logic [DATA_W-1:0]   src_a;
    logic                src_a_is_addr;
    logic [DATA_W-1:0]   src_b;
    logic                src_b_is_addr;
    logic [TARGET_W-1:0] jump_target;
    logic [DATA_W-1:0]   read_value;
  } instr_t;

  // outcome of one executed instruction
  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic [PC_W-1:0]   next_pc;
    logic              show_valid;
    logic [DATA_W-1:0] show_index;
    logic              halted;
    logic              store_en;
  } exec_t;

endpackage

FILE: sv/tie_if.sv
// ----------------------------------------------------------------------------
// tie_if
// Valid/ready channels of the toy ISA execute unit: one for decoded
// instructions, one for execute results.
// ----------------------------------------------------------------------------
interface tie_instr_if;
  logic        valid;
  logic        ready;
  logic [3:0]  mode;
  logic signed [31:0] src_a;
  logic        src_a_is_addr;
  logic signed [31:0] src_b;
  logic        src_b_is_addr;
  logic [9:0]  dest_addr;
  logic [10:0] jump_target;
  logic signed [31:0] read_value;

  modport source (
    output valid, mode, src_a, src_a_is_addr, src_b, src_b_is_addr,
           dest_addr, jump_target, read_value,
    input  ready
  );
  modport sink (
    input  valid, mode, src_a, src_a_is_addr, src_b, src_b_is_addr,
           dest_addr, jump_target, read_value,
    output ready
  );
endinterface

interface tie_result_if;
  logic        valid;
  logic        ready;
  logic signed [31:0] result_value;
  logic [9:0]  next_pc;
  logic        show_valid;
  logic signed [31:0] show_index;
  logic        halted;

  modport source (
    output valid, result_value, next_pc, show_valid, show_index, halted,
    input  ready
  );
  modport sink (
    input  valid, result_value, next_pc, show_valid, show_index, halted,
    output ready
  );
endinterface

FILE: sv/tie_store.sv
// ----------------------------------------------------------------------------
// tie_store
// Data store: one write port, two read ports with registered read data.
// Read data holds while no read is issued.
// ----------------------------------------------------------------------------
module tie_store #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

FILE: sv/tie_alu.sv
// ----------------------------------------------------------------------------
// tie_alu
// Execute logic: operation, next program counter, halt and store enable
// for one instruction given its resolved operands.
// ----------------------------------------------------------------------------
module tie_alu
  import tie_pkg::*;
(
  input  instr_t            instr,
  input  logic [DATA_W-1:0] opnd_a,
  input  logic [DATA_W-1:0] opnd_b,
  input  logic [PC_W-1:0]   pc,
  input  logic              halt_flag,
  output exec_t             ex
);

  logic [DATA_W-1:0]   product;
  logic [PC_W-1:0]     jump_pc;
  logic [PC_W-1:0]     inc_pc;

  // low word of the product only
  assign product = opnd_a * opnd_b;
  // one-based line to zero-based counter, wrapping
  assign jump_pc = instr.jump_target[PC_W-1:0] - PC_W'(1);
  assign inc_pc  = pc + PC_W'(1);

  always_comb begin
    ex.value      = '0;
    ex.next_pc    = inc_pc;
    ex.show_valid = 1'b0;
    ex.show_index = '0;
    ex.halted     = halt_flag;
    ex.store_en   = 1'b0;
    if (halt_flag) begin
      ex.next_pc = pc;
    end else begin
      unique case (instr.mode)
        OP_ADD: begin
          ex.value    = opnd_a + opnd_b;
          ex.store_en = 1'b1;
        end
        OP_NEG: begin
          ex.value    = '0 - opnd_a;
          ex.store_en = 1'b1;
        end
        OP_MUL: begin
          ex.value    = product;
          ex.store_en = 1'b1;
        end
        OP_JMP: begin
          ex.next_pc = jump_pc;
        end
        OP_JMP0: begin
          if (opnd_a == '0) begin
            ex.next_pc = jump_pc;
          end
        end
        OP_ASS: begin
          ex.value    = opnd_a;
          ex.store_en = 1'b1;
        end
        OP_LE: begin
          ex.value    = {{(DATA_W-1){1'b0}}, ($signed(opnd_a) <= $signed(opnd_b))};
          ex.store_en = 1'b1;
        end
        OP_READ: begin
          ex.value    = instr.read_value;
          ex.store_en = 1'b1;
        end
        OP_WRITE: begin
          ex.value      = opnd_a;
          ex.show_valid = 1'b1;
          ex.show_index = instr.src_a;
        end
        OP_HALT: begin
          ex.halted  = 1'b1;
          ex.next_pc = pc;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

FILE: sv/toy_isa_execute_unit.sv
// ----------------------------------------------------------------------------
// toy_isa_execute_unit
// Executes decoded toy ISA instructions against a zero-initialized data
// store, keeping a program counter and a halt flag.
//
//   channel | dir | handshake     | payload
//   --------+-----+---------------+----------------------------------------
//   instr   | in  | valid / ready | mode, src_a/b (+is_addr), dest_addr,
//           |     |               | jump_target, read_value
//   res     | out | valid / ready | result_value, next_pc, show_valid,
//           |     |               | show_index, halted
//
// One transaction per cycle sustained while res.ready stays high. The store's
// read ports are driven in the accept cycle; execute and write-back happen
// when the execute stage advances, which loads the result register, so a
// result is valid once its instruction leaves the execute stage.
// After reset a clearing pass zeroes the store, one word a cycle, over all
// STORE_WORDS words; instr.ready stays low meanwhile.
// A stalled result holds the executing instruction and its read data.
// STORE_WORDS must be a power of two; store addresses take its low bits.
// ----------------------------------------------------------------------------
module toy_isa_execute_unit
  import tie_pkg::*;
#(
  parameter int STORE_WORDS = 1024
) (
  input  logic         clk,
  input  logic         rst,
  tie_instr_if.sink    instr,
  tie_result_if.source res
);

  localparam int AW = $clog2(STORE_WORDS);

  // clearing pass
  logic          clearing;
  logic [AW-1:0] clr_addr;

  // execute stage: instruction waiting on its read data
  logic          s1_vld;
  instr_t        s1;
  logic [AW-1:0] s1_a_idx;
  logic [AW-1:0] s1_b_idx;
  logic [AW-1:0] s1_dest_idx;
  logic          s1_adv;

  // architectural state
  logic [PC_W-1:0] pc;
  logic            halt_flag;

  // last store write, used to patch read data that missed it
  logic              fwd_vld;
  logic [AW-1:0]     fwd_addr;
  logic [DATA_W-1:0] fwd_data;

  // result register
  logic  out_vld;
  exec_t out_q;

  logic              accept;
  logic [DATA_W-1:0] a_ext;
  logic [DATA_W-1:0] b_ext;
  logic [DATA_W-1:0] dest_ext;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [DATA_W-1:0] mem_wdata;
  logic [DATA_W-1:0] rdata_a;
  logic [DATA_W-1:0] rdata_b;
  logic [DATA_W-1:0] opnd_a;
  logic [DATA_W-1:0] opnd_b;
  exec_t             ex;

  // advance when the result register is empty or being drained
  assign s1_adv      = s1_vld && (!out_vld || res.ready);
  assign instr.ready = !clearing && (!s1_vld || s1_adv);
  assign accept      = instr.valid && instr.ready;

  // addresses wrap modulo the store size
  assign a_ext    = instr.src_a;
  assign b_ext    = instr.src_b;
  assign dest_ext = DATA_W'(instr.dest_addr);

  // clearing pass: sweep the store once after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + AW'(1);
      if (clr_addr == AW'(STORE_WORDS - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  // capture the accepted instruction alongside its store read
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else if (accept) begin
      s1_vld <= 1'b1;
    end else if (s1_adv) begin
      s1_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1.mode          <= instr.mode;
      s1.src_a         <= instr.src_a;
      s1.src_a_is_addr <= instr.src_a_is_addr;
      s1.src_b         <= instr.src_b;
      s1.src_b_is_addr <= instr.src_b_is_addr;
      s1.jump_target   <= instr.jump_target;
      s1.read_value    <= instr.read_value;
      s1_a_idx         <= a_ext[AW-1:0];
      s1_b_idx         <= b_ext[AW-1:0];
      s1_dest_idx      <= dest_ext[AW-1:0];
    end
  end

  // write port: clearing pass first, then instruction write-back
  assign mem_we    = clearing || (s1_adv && ex.store_en);
  assign mem_waddr = clearing ? clr_addr : s1_dest_idx;
  assign mem_wdata = clearing ? '0 : ex.value;

  tie_store #(
    .DEPTH (STORE_WORDS),
    .WIDTH (DATA_W)
  ) u_store (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wdata   (mem_wdata),
    .re      (accept),
    .raddr_a (a_ext[AW-1:0]),
    .raddr_b (b_ext[AW-1:0]),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  // Hold a copy of the latest write-back. A read issued in the same cycle
  // as that write returns the old word; the copy always matches the store,
  // so using it on an address match is safe whenever the read was issued.
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_vld <= 1'b0;
    end else if (s1_adv && ex.store_en) begin
      fwd_vld <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && ex.store_en) begin
      fwd_addr <= s1_dest_idx;
      fwd_data <= ex.value;
    end
  end

  // resolve operands: immediate, forwarded word or store word
  always_comb begin
    if (!s1.src_a_is_addr) begin
      opnd_a = s1.src_a;
    end else if (fwd_vld && (fwd_addr == s1_a_idx)) begin
      opnd_a = fwd_data;
    end else begin
      opnd_a = rdata_a;
    end
    if (!s1.src_b_is_addr) begin
      opnd_b = s1.src_b;
    end else if (fwd_vld && (fwd_addr == s1_b_idx)) begin
      opnd_b = fwd_data;
    end else begin
      opnd_b = rdata_b;
    end
  end

  tie_alu u_alu (
    .instr     (s1),
    .opnd_a    (opnd_a),
    .opnd_b    (opnd_b),
    .pc        (pc),
    .halt_flag (halt_flag),
    .ex        (ex)
  );

  // commit program counter and halt flag as the instruction advances
  always_ff @(posedge clk) begin
    if (rst) begin
      pc        <= '0;
      halt_flag <= 1'b0;
    end else if (s1_adv) begin
      pc        <= ex.next_pc;
      halt_flag <= ex.halted;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (s1_adv) begin
      out_vld <= 1'b1;
    end else if (res.ready) begin
      out_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_q <= ex;
    end
  end

  assign res.valid        = out_vld;
  assign res.result_value = out_q.value;
  assign res.next_pc      = out_q.next_pc;
  assign res.show_valid   = out_q.show_valid;
  assign res.show_index   = out_q.show_index;
  assign res.halted       = out_q.halted;

`ifndef SYNTHESIS
  // once halted, stay halted until reset
  a_halt_sticky: assert property (@(posedge clk) disable iff (rst)
    halt_flag |=> halt_flag)
    else $error("halt flag cleared without reset");

  // no instruction write-back while halted or during the clearing pass
  a_no_store_halted: assert property (@(posedge clk) disable iff (rst)
    (s1_adv && ex.store_en) |-> (!halt_flag && !clearing))
    else $error("store written while halted or clearing");

  // program counter moves only when an instruction commits
  a_pc_stable: assert property (@(posedge clk) disable iff (rst)
    !s1_adv |=> $stable(pc))
    else $error("program counter changed without a commit");

  // a stalled executing instruction keeps its place
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    (s1_vld && out_vld && !res.ready) |=> (s1_vld && $stable(s1)))
    else $error("executing instruction lost during stall");
`endif

endmodule
